### rtl/core/kld_pkg.sv
// keypad long-press detector: shared types, codes, reset values and helpers
`default_nettype none
package kld_pkg;

  localparam int KEY_COUNT = 4;
  localparam int TICK_W    = 16;

  typedef logic [1:0]           op_t;
  typedef logic [2:0]           key_t;
  typedef logic [KEY_COUNT-1:0] key_mask_t;
  typedef logic [TICK_W-1:0]    ticks_t;
  typedef logic [1:0]           cfg_index_t;

  // item kinds
  localparam op_t OP_TICK    = 2'd0;
  localparam op_t OP_PRESS   = 2'd1;
  localparam op_t OP_RELEASE = 2'd2;
  localparam op_t OP_UNUSED  = 2'd3;

  // register indexes
  localparam cfg_index_t CFG_LONG_PRESS = 2'd0;
  localparam cfg_index_t CFG_REPEAT     = 2'd1;
  localparam cfg_index_t CFG_BACKLIGHT  = 2'd2;

  // register reset values
  localparam ticks_t LONG_PRESS_RESET = 16'd300;
  localparam ticks_t REPEAT_RESET     = 16'd100;
  localparam ticks_t BACKLIGHT_RESET  = 16'd1000;

  // an interval of zero loads as one
  function automatic ticks_t load_value(input ticks_t v);
    return (v == '0) ? ticks_t'(1) : v;
  endfunction

endpackage
`default_nettype wire

### rtl/core/keypad_long_press_detector.sv
// keypad long-press detector top level: timers, skip flags and result register
// Usage:
//   Input channel (in_valid / in_stall) carries op, key and key_levels; a
//   request is taken at a rising edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall) carries short_events, long_events,
//   backlight_on and key_error; exactly one result per input request.
//   Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes the
//   long-press, repeat and backlight intervals; cfg_ready is always high and
//   an index beyond the three registers is ignored.
// Result and throughput:
//   the result of a request is written into the output register at the edge
//   at which it is accepted; one request per cycle is taken while in_stall is
//   low, since the whole update of the two down-counters and the flags is a
//   single pass of logic into the state and result registers.
// Stall:
//   while the output register holds a result and out_stall is high, in_stall
//   is raised and nothing moves; a waiting result is replaced in the same
//   cycle it is taken.
// Reset (rst, synchronous, active high):
//   registers return to 300 / 100 / 1000 ticks, the hold timer is stopped,
//   the backlight timer runs with 1000 ticks, backlight off, no error, and
//   the output register is empty.
`default_nettype none
module keypad_long_press_detector (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire kld_pkg::op_t          op,
  input  wire kld_pkg::key_t         key,
  input  wire kld_pkg::key_mask_t    key_levels,
  // output channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output kld_pkg::key_mask_t         short_events,
  output kld_pkg::key_mask_t         long_events,
  output logic                       backlight_on,
  output logic                       key_error,
  // config channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire kld_pkg::cfg_index_t   cfg_index,
  input  wire kld_pkg::ticks_t       cfg_data
);
  import kld_pkg::*;

  ticks_t    long_press_ticks;
  ticks_t    repeat_ticks;
  ticks_t    backlight_ticks;

  ticks_t    hold_count;
  logic      hold_active;
  key_mask_t skip_flags;
  ticks_t    backlight_count;
  logic      backlight_active;
  logic      light_state;
  logic      error_latch;

  ticks_t    hold_count_next;
  logic      hold_active_next;
  key_mask_t skip_flags_next;
  ticks_t    backlight_count_next;
  logic      backlight_active_next;
  logic      light_state_next;
  logic      error_latch_next;
  key_mask_t short_next;
  key_mask_t long_next;

  ticks_t    hold_dec;
  ticks_t    backlight_dec;
  key_mask_t key_bit;
  logic      key_known;
  logic      in_take;

  // handshake
  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign in_take   = in_valid && !in_stall;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= LONG_PRESS_RESET;
      repeat_ticks     <= REPEAT_RESET;
      backlight_ticks  <= BACKLIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LONG_PRESS: long_press_ticks <= cfg_data;
        CFG_REPEAT:     repeat_ticks     <= cfg_data;
        CFG_BACKLIGHT:  backlight_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturating countdowns and key decode
  assign hold_dec      = (hold_count != '0) ? hold_count - ticks_t'(1) : '0;
  assign backlight_dec = (backlight_count != '0) ? backlight_count - ticks_t'(1) : '0;
  assign key_known     = (key < key_t'(KEY_COUNT));
  assign key_bit       = key_known ? key_mask_t'(1) << key[1:0] : '0;

  // next state and result for one request
  always_comb begin
    hold_count_next       = hold_count;
    hold_active_next      = hold_active;
    skip_flags_next       = skip_flags;
    backlight_count_next  = backlight_count;
    backlight_active_next = backlight_active;
    light_state_next      = light_state;
    error_latch_next      = error_latch;
    short_next            = '0;
    long_next             = '0;
    unique case (op)
      OP_TICK: begin
        if (hold_active) begin
          if (hold_dec == '0) begin
            long_next       = key_levels;
            skip_flags_next = skip_flags | key_levels;
            hold_count_next = load_value(repeat_ticks);
          end else begin
            hold_count_next = hold_dec;
          end
        end
        if (backlight_active) begin
          backlight_count_next = backlight_dec;
          if (backlight_dec == '0) begin
            backlight_active_next = 1'b0;
            light_state_next      = 1'b0;
          end
        end
      end
      OP_PRESS: begin
        hold_count_next  = load_value(long_press_ticks);
        hold_active_next = 1'b1;
        light_state_next = 1'b1;
      end
      OP_RELEASE: begin
        hold_active_next      = 1'b0;
        backlight_count_next  = load_value(backlight_ticks);
        backlight_active_next = 1'b1;
        if (!key_known) begin
          error_latch_next = 1'b1;
        end else if ((skip_flags & key_bit) != '0) begin
          skip_flags_next = skip_flags & ~key_bit;
        end else begin
          short_next = key_bit;
        end
      end
      OP_UNUSED: ;
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count       <= '0;
      hold_active      <= 1'b0;
      skip_flags       <= '0;
      backlight_count  <= BACKLIGHT_RESET;
      backlight_active <= 1'b1;
      light_state      <= 1'b0;
      error_latch      <= 1'b0;
    end else if (in_take) begin
      hold_count       <= hold_count_next;
      hold_active      <= hold_active_next;
      skip_flags       <= skip_flags_next;
      backlight_count  <= backlight_count_next;
      backlight_active <= backlight_active_next;
      light_state      <= light_state_next;
      error_latch      <= error_latch_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      short_events <= short_next;
      long_events  <= long_next;
      backlight_on <= light_state_next;
      key_error    <= error_latch_next;
    end
  end

`ifndef SYNTHESIS
  // short and long events never come in the same result
  a_events_disjoint: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((short_events & long_events) == '0))
    else $error("short and long events in one result");

  // at most one short event per result
  a_short_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0(short_events))
    else $error("more than one short event");

  // the error flag stays set until reset
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    error_latch |=> error_latch)
    else $error("error latch cleared");

  // a release stops the hold timer
  a_release_stops_hold: assert property (@(posedge clk) disable iff (rst)
    (in_take && (op == OP_RELEASE)) |=> !hold_active)
    else $error("hold timer still active after release");
`endif

endmodule
`default_nettype wire

### tb/sv/keypad_long_press_detector_tb.sv
// self-checking testbench for the keypad long-press detector: directed, pressure and random tests
`timescale 1ns / 100ps

module keypad_long_press_detector_tb;
  import kld_pkg::*;

  // key codes of the four known keys
  localparam key_t KEY_ENTER = 3'd0;
  localparam key_t KEY_DOWN  = 3'd1;
  localparam key_t KEY_ESC   = 3'd2;
  localparam key_t KEY_UP    = 3'd3;
  // an index past the three registers, written to check that it is ignored
  localparam cfg_index_t CFG_NONE = 2'd3;

  localparam int ITEM_GOAL = 1850;

  typedef struct packed {
    key_mask_t short_ev;
    key_mask_t long_ev;
    logic      lit;
    logic      err;
  } key_events_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  op_t        op;
  key_t       key;
  key_mask_t  key_levels;
  logic       out_valid;
  logic       out_stall;
  key_mask_t  short_events;
  key_mask_t  long_events;
  logic       backlight_on;
  logic       key_error;
  logic       cfg_valid;
  logic       cfg_ready;
  cfg_index_t cfg_index;
  ticks_t     cfg_data;

  // predicted register and timer state
  ticks_t    long_ivl;
  ticks_t    repeat_ivl;
  ticks_t    light_ivl;
  ticks_t    hold_cnt;
  logic      hold_run;
  key_mask_t skip_mask;
  ticks_t    light_cnt;
  logic      light_run;
  logic      light_lit;
  logic      err_seen;

  key_events_t key_events_due[$];
  int          mismatches   = 0;
  int          items_sent   = 0;
  int          choke_cycles = 0;
  bit          calm         = 1'b0;

  keypad_long_press_detector dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .key(key),
    .key_levels(key_levels),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .short_events(short_events),
    .long_events(long_events),
    .backlight_on(backlight_on),
    .key_error(key_error),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // expected events of one request, advancing the predicted state
  function automatic key_events_t compute_key_events(op_t o, key_t k, key_mask_t lv);
    key_events_t r;
    r = '0;
    case (o)
      OP_TICK: begin
        if (hold_run) begin
          if (hold_cnt != '0) hold_cnt = hold_cnt - ticks_t'(1);
          if (hold_cnt == '0) begin
            r.long_ev = lv;
            skip_mask = skip_mask | lv;
            hold_cnt  = (repeat_ivl == '0) ? ticks_t'(1) : repeat_ivl;
          end
        end
        if (light_run) begin
          if (light_cnt != '0) light_cnt = light_cnt - ticks_t'(1);
          if (light_cnt == '0) begin
            light_run = 1'b0;
            light_lit = 1'b0;
          end
        end
      end
      OP_PRESS: begin
        hold_cnt  = (long_ivl == '0) ? ticks_t'(1) : long_ivl;
        hold_run  = 1'b1;
        light_lit = 1'b1;
      end
      OP_RELEASE: begin
        hold_run  = 1'b0;
        light_cnt = (light_ivl == '0) ? ticks_t'(1) : light_ivl;
        light_run = 1'b1;
        if (k < key_t'(KEY_COUNT)) begin
          if (skip_mask[k[1:0]]) skip_mask[k[1:0]] = 1'b0;
          else r.short_ev[k[1:0]] = 1'b1;
        end else begin
          err_seen = 1'b1;
        end
      end
      default: ;
    endcase
    r.lit = light_lit;
    r.err = err_seen;
    return r;
  endfunction

  // send one request; valid stays high when the next one follows at once
  task automatic send_item(input op_t o, input key_t k, input key_mask_t lv);
    in_valid   <= 1'b1;
    op         <= o;
    key        <= k;
    key_levels <= lv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    key_events_due.push_back(compute_key_events(o, k, lv));
    items_sent++;
    if (!calm && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  // one register write; valid is kept high unless this is the last of a group
  task automatic write_reg(input cfg_index_t idx, input ticks_t d, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (last) cfg_valid <= 1'b0;
    case (idx)
      CFG_LONG_PRESS: long_ivl   = d;
      CFG_REPEAT:     repeat_ivl = d;
      CFG_BACKLIGHT:  light_ivl  = d;
      default: ;
    endcase
  endtask

  task automatic write_intervals(input ticks_t lp, input ticks_t rp, input ticks_t bl);
    write_reg(CFG_LONG_PRESS, lp, 1'b0);
    write_reg(CFG_REPEAT, rp, 1'b0);
    write_reg(CFG_BACKLIGHT, bl, 1'b1);
  endtask

  // stop sending and wait until every expected result has come out
  task automatic settle();
    in_valid <= 1'b0;
    while (key_events_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // press and release of every key, unknown keys, unused op, default intervals
  task automatic test_directed_edges();
    send_item(OP_TICK, KEY_ENTER, 4'h0);
    send_item(OP_UNUSED, 3'd7, 4'hF);
    send_item(OP_PRESS, KEY_ENTER, 4'h1);
    send_item(OP_RELEASE, KEY_ENTER, 4'h0);
    send_item(OP_PRESS, KEY_DOWN, 4'h2);
    send_item(OP_RELEASE, KEY_DOWN, 4'h0);
    send_item(OP_PRESS, KEY_ESC, 4'h4);
    send_item(OP_RELEASE, KEY_ESC, 4'h0);
    send_item(OP_PRESS, KEY_UP, 4'h8);
    send_item(OP_RELEASE, KEY_UP, 4'h0);
    send_item(OP_PRESS, 3'd4, 4'h0);
    send_item(OP_RELEASE, 3'd7, 4'hF);
    send_item(OP_TICK, KEY_UP, 4'hF);
    settle();
  endtask

  // shortest and zero intervals, both timers expiring together, ignored index, longest
  task automatic test_interval_extremes();
    write_intervals(16'd1, 16'd0, 16'd0);
    send_item(OP_PRESS, KEY_DOWN, 4'h0);
    send_item(OP_TICK, KEY_ENTER, 4'hF);
    send_item(OP_RELEASE, KEY_DOWN, 4'h0);
    send_item(OP_PRESS, KEY_ENTER, 4'h0);
    send_item(OP_TICK, KEY_ENTER, 4'h5);
    send_item(OP_RELEASE, KEY_ENTER, 4'h0);
    send_item(OP_RELEASE, KEY_UP, 4'h0);
    send_item(OP_RELEASE, KEY_ESC, 4'h0);
    send_item(OP_RELEASE, KEY_ESC, 4'h0);
    send_item(OP_TICK, KEY_ESC, 4'h0);
    settle();
    write_reg(CFG_NONE, 16'd5, 1'b1);
    write_intervals(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(OP_PRESS, KEY_UP, 4'h8);
    send_item(OP_TICK, KEY_UP, 4'hF);
    send_item(OP_TICK, KEY_UP, 4'h0);
    send_item(OP_RELEASE, KEY_UP, 4'h0);
    settle();
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    write_intervals(16'd2, 16'd1, 16'd3);
    calm = 1'b1;
    choke_cycles = 150;
    repeat (40) send_item(op_t'($urandom_range(0, 2)), key_t'($urandom), key_mask_t'($urandom));
    calm = 1'b0;
    settle();
  endtask

  // press, a run of ticks with the key mostly held, then release
  task automatic send_hold_sequence();
    key_t      k;
    key_mask_t lv;
    int        n;
    if ($urandom_range(0, 9) == 0) k = key_t'($urandom_range(4, 7));
    else k = key_t'($urandom_range(0, 3));
    send_item(OP_PRESS, k, key_mask_t'($urandom));
    n = $urandom_range(0, 14);
    repeat (n) begin
      lv = key_mask_t'($urandom);
      if (k < key_t'(KEY_COUNT) && $urandom_range(0, 9) < 7) lv[k[1:0]] = 1'b1;
      send_item(OP_TICK, key_t'($urandom), lv);
    end
    if ($urandom_range(0, 9) == 0) k = key_t'($urandom);
    send_item(OP_RELEASE, k, key_mask_t'($urandom));
  endtask

  function automatic ticks_t pick_interval();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return '0;
    if (p == 1) return 16'hFFFF;
    return ticks_t'($urandom_range(1, 10));
  endfunction

  // random phases, each with its own intervals; one phase runs without idling
  task automatic test_random_sequences();
    int phase;
    int goal;
    int pick;
    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      if (phase == 0) write_intervals(16'd1, 16'd1, 16'd1);
      else write_intervals(pick_interval(), pick_interval(), pick_interval());
      calm = (phase == 2);
      goal = items_sent + 300;
      while (items_sent < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          send_hold_sequence();
        end else if (pick < 85) begin
          repeat ($urandom_range(1, 12))
            send_item(OP_TICK, key_t'($urandom), key_mask_t'($urandom));
        end else begin
          send_item(op_t'($urandom), key_t'($urandom), key_mask_t'($urandom));
        end
      end
      calm = 1'b0;
      settle();
      phase++;
    end
  endtask

  task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // compare each taken result with the oldest expectation
  always @(posedge clk) begin : check_results
    key_events_t want;
    if (!rst && out_valid && !out_stall) begin
      if (key_events_due.size() == 0) begin
        $display("%0t: result with none expected, actual %h %h %b %b", $time,
                 short_events, long_events, backlight_on, key_error);
        mismatches++;
      end else begin
        want = key_events_due.pop_front();
        check_field("short_events", want.short_ev, short_events);
        check_field("long_events", want.long_ev, long_events);
        check_field("backlight_on", {3'b0, want.lit}, {3'b0, backlight_on});
        check_field("key_error", {3'b0, want.err}, {3'b0, key_error});
      end
    end
  end

  // receiver stalls, with a counted hold-off when one is requested
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (choke_cycles > 0) begin
        out_stall <= 1'b1;
        choke_cycles--;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 27);
      end
    end
  end

  // run limit
  initial begin
    #2000000;
    $display("keypad_long_press_detector test failed");
    $finish;
  end

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    op         <= OP_TICK;
    key        <= KEY_ENTER;
    key_levels <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_LONG_PRESS;
    cfg_data   <= '0;
    long_ivl   = LONG_PRESS_RESET;
    repeat_ivl = REPEAT_RESET;
    light_ivl  = BACKLIGHT_RESET;
    hold_cnt   = '0;
    hold_run   = 1'b0;
    skip_mask  = '0;
    light_cnt  = BACKLIGHT_RESET;
    light_run  = 1'b1;
    light_lit  = 1'b0;
    err_seen   = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_interval_extremes();
    test_backpressure();
    test_random_sequences();
    settle();
    if (mismatches == 0) begin
      $display("keypad_long_press_detector test passed");
    end else begin
      $display("keypad_long_press_detector test failed");
    end
    $finish;
  end

endmodule

### keypad_long_press_detector.f
rtl/core/kld_pkg.sv
rtl/core/keypad_long_press_detector.sv
tb/sv/keypad_long_press_detector_tb.sv
